FILE: src/vac_pkg.sv
// Shared types and constants for the voice allocator.
// Used by the front end, the command queue, the engine and the top level.
`timescale 1ns / 1ps

package vac_pkg;

    localparam int DEF_NUM_VOICES  = 8;
    localparam int DEF_QUEUE_DEPTH = 4;

    // Function code of an input item
    typedef enum logic [1:0] {
        FN_NOTE_ON  = 2'd0,
        FN_NOTE_OFF = 2'd1,
        FN_STATUS   = 2'd2,
        FN_TICK     = 2'd3
    } t_func;

    // Action code of a result item
    typedef enum logic {
        ACT_START   = 1'b0,
        ACT_RELEASE = 1'b1
    } t_action;

    // Engine sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_FLUSH
    } t_eng_state;

    // Classified command passed from the front end to the engine
    typedef struct packed {
        t_func        func;
        logic [31:0]  note;
        logic [31:0]  dur;
        logic [2:0]   sel;
        logic         act;
        logic [15:0]  level;
    } t_cmd;

    // One result item
    typedef struct packed {
        t_action      action;
        logic [2:0]   voice;
        logic [31:0]  note;
    } t_result;

endpackage

FILE: src/synth_voice_allocator_unit.sv
// Polyphonic voice allocator with voice stealing, top level.
// Input channel: i_in_valid / o_in_stall with the item fields; an item is taken
// at a clock edge with valid high and stall low. Stall rises only while the
// command queue is full.
// Output channel: o_out_valid / i_out_stall with action, voice index, note id
// and a last flag on the final result of each item. Items that cause no result
// (status reports, note on with id zero, unmatched note off) give nothing.
// Rate: the engine walks the voice slots one voice per cycle, except while a
// release result waits on a stalled receiver. A note on ends with a commit
// step, a note off or frame tick with a flush step; a status report ends in idle.
// A start result goes straight to the result register; a release result waits
// in a hold register first. A stalled receiver holds the result register and
// the engine waits, while the queue keeps taking items until it is full.
// Reset (synchronous, active low) frees all voices, empties the queue and sets
// the start order counter to one.
// Depends on vac_pkg, vac_front, vac_queue and vac_engine.
`timescale 1ns / 1ps

module synth_voice_allocator_unit #(
    parameter int NUM_VOICES  = vac_pkg::DEF_NUM_VOICES,
    parameter int QUEUE_DEPTH = vac_pkg::DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_note_id,
    input  logic [31:0] i_duration_frames,
    input  logic [2:0]  i_voice_select,
    input  logic        i_voice_active,
    input  logic [15:0] i_envelope_level,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_action,
    output logic [2:0]  o_voice_index,
    output logic [31:0] o_note_id_out,
    output logic        o_last
);
    import vac_pkg::*;

    logic push, full, pop, empty;
    t_cmd cmd, head;

    // Classify incoming items
    vac_front #(
        .NUM_VOICES (NUM_VOICES)
    ) u_front (
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_note_id         (i_note_id),
        .i_duration_frames (i_duration_frames),
        .i_voice_select    (i_voice_select),
        .i_voice_active    (i_voice_active),
        .i_envelope_level  (i_envelope_level),
        .i_full            (full),
        .o_push            (push),
        .o_cmd             (cmd)
    );

    // Decouple front and engine
    vac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    // Carry out commands on the voice slots
    vac_engine #(
        .NUM_VOICES (NUM_VOICES)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_action      (o_action),
        .o_voice_index (o_voice_index),
        .o_note_id_out (o_note_id_out),
        .o_last        (o_last)
    );

endmodule

FILE: src/vac_front.sv
// Input front end: accepts items and turns them into queue commands.
// Depends on vac_pkg; feeds vac_queue.
`timescale 1ns / 1ps

module vac_front #(
    parameter int NUM_VOICES = vac_pkg::DEF_NUM_VOICES
) (
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_func,
    input  logic [31:0]   i_note_id,
    input  logic [31:0]   i_duration_frames,
    input  logic [2:0]   i_voice_select,
    input  logic          i_voice_active,
    input  logic [15:0]   i_envelope_level,
    input  logic          i_full,
    output logic          o_push,
    output vac_pkg::t_cmd o_cmd
);
    import vac_pkg::*;

    logic keep;

    // Build the command from the item fields
    always_comb begin
        o_cmd.func  = t_func'(i_func);
        o_cmd.note  = i_note_id;
        o_cmd.dur   = i_duration_frames;
        o_cmd.sel   = i_voice_select;
        o_cmd.act   = i_voice_active;
        o_cmd.level = i_envelope_level;
    end

    // Drop items that change nothing: note on with the free id, status of a missing voice
    always_comb begin
        unique case (t_func'(i_func))
            FN_NOTE_ON: keep = (i_note_id != 32'd0);
            FN_STATUS:  keep = (8'(i_voice_select) < 8'(NUM_VOICES));
            default:    keep = 1'b1;
        endcase
    end

    // Hold off the sender while the queue is full
    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full && keep;

endmodule

FILE: src/vac_queue.sv
// Short command queue between the front end and the engine.
// Depends on vac_pkg for the command type.
`timescale 1ns / 1ps

module vac_queue #(
    parameter int DEPTH = vac_pkg::DEF_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vac_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output vac_pkg::t_cmd o_head
);
    import vac_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   n_wr_ptr;
    logic [AW-1:0]   n_rd_ptr;
    logic [CW-1:0]   n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed command
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

endmodule

FILE: src/vac_engine.sv
// Voice engine: holds the voice slots, walks them one voice per cycle per command while no release
// result waits on a stalled output, and drives the result register. Depends on vac_pkg; fed by vac_queue.
`timescale 1ns / 1ps

module vac_engine #(
    parameter int NUM_VOICES = vac_pkg::DEF_NUM_VOICES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  vac_pkg::t_cmd i_head,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic          o_action,
    output logic [2:0]    o_voice_index,
    output logic [31:0]   o_note_id_out,
    output logic          o_last
);
    import vac_pkg::*;

    localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    // Voice slots
    logic [31:0]   r_note  [NUM_VOICES];
    logic [31:0]   r_cd    [NUM_VOICES];
    logic [63:0]   r_ord   [NUM_VOICES];
    logic          r_rel   [NUM_VOICES];
    logic          r_act   [NUM_VOICES];
    logic [15:0]   r_lvl   [NUM_VOICES];
    logic [63:0]   r_start_cnt, n_start_cnt;

    // Sequencer
    t_eng_state    r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [VW-1:0] r_idx, n_idx;

    // Note-on search trackers
    logic          r_match_found, n_match_found;
    logic [VW-1:0] r_match_idx, n_match_idx;
    logic          r_free_found, n_free_found;
    logic [VW-1:0] r_free_idx, n_free_idx;
    logic          r_steal_have, n_steal_have;
    logic [VW-1:0] r_steal_idx, n_steal_idx;
    logic          r_best_rel, n_best_rel;
    logic [15:0]   r_best_lvl, n_best_lvl;
    logic [63:0]   r_best_ord, n_best_ord;

    // Held result waiting to learn whether it is the final one
    logic          r_hold_valid, n_hold_valid;
    t_result       r_hold, n_hold;

    // Result register
    logic          r_out_valid;
    t_result       r_out;
    logic          r_out_last;
    logic          out_free;
    logic          push;
    t_result       push_res;
    logic          push_last;

    // Slot write port
    logic [VW-1:0] wr_idx;
    logic          wr_key_en, wr_cd_en, wr_rel_en, wr_act_en;
    logic [31:0]   wr_note, wr_cd;
    logic [63:0]   wr_ord;
    logic          wr_rel, wr_act;
    logic [15:0]   wr_lvl;

    // Current voice of the scan
    logic [31:0]   cur_note, cur_cd, cd_dec;
    logic [63:0]   cur_ord;
    logic          cur_rel, cur_act, cur_last;
    logic [15:0]   cur_lvl;
    logic          hit, stop, can_go, take;
    logic [VW-1:0] pick;

    assign cur_note = r_note[r_idx];
    assign cur_cd   = r_cd[r_idx];
    assign cur_ord  = r_ord[r_idx];
    assign cur_rel  = r_rel[r_idx];
    assign cur_act  = r_act[r_idx];
    assign cur_lvl  = r_lvl[r_idx];
    assign cur_last = (r_idx == VW'(NUM_VOICES - 1));
    assign cd_dec   = cur_cd - 32'd1;
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state, slot writes and result pushes
    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_idx         = r_idx;
        n_match_found = r_match_found;
        n_match_idx   = r_match_idx;
        n_free_found  = r_free_found;
        n_free_idx    = r_free_idx;
        n_steal_have  = r_steal_have;
        n_steal_idx   = r_steal_idx;
        n_best_rel    = r_best_rel;
        n_best_lvl    = r_best_lvl;
        n_best_ord    = r_best_ord;
        n_hold_valid  = r_hold_valid;
        n_hold        = r_hold;
        n_start_cnt   = r_start_cnt;
        o_pop         = 1'b0;
        push          = 1'b0;
        push_res      = r_hold;
        push_last     = 1'b0;
        wr_idx        = r_idx;
        wr_key_en     = 1'b0;
        wr_cd_en      = 1'b0;
        wr_rel_en     = 1'b0;
        wr_act_en     = 1'b0;
        wr_note       = 32'd0;
        wr_ord        = 64'd0;
        wr_cd         = 32'd0;
        wr_rel        = 1'b0;
        wr_act        = 1'b0;
        wr_lvl        = 16'd0;
        hit           = 1'b0;
        stop          = cur_last;
        can_go        = 1'b0;
        take          = 1'b0;
        pick          = '0;

        unique case (r_state)
            ST_IDLE: begin
                // Take the next command; status reports finish here
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_head;
                    if (i_head.func == FN_STATUS) begin
                        wr_idx    = VW'(i_head.sel);
                        wr_act_en = 1'b1;
                        wr_act    = i_head.act;
                        wr_lvl    = i_head.level;
                    end else begin
                        n_state       = ST_SCAN;
                        n_idx         = '0;
                        n_match_found = 1'b0;
                        n_free_found  = 1'b0;
                        n_steal_have  = 1'b0;
                    end
                end
            end

            ST_SCAN: begin
                // Decide whether this voice yields a release result
                unique case (r_cmd.func)
                    FN_NOTE_OFF: begin
                        if (r_cmd.note == 32'd0) begin
                            hit = (cur_note != 32'd0) && cur_act;
                        end else begin
                            hit  = (cur_note == r_cmd.note) && cur_act;
                            stop = (cur_note == r_cmd.note) || cur_last;
                        end
                    end
                    FN_TICK: begin
                        hit = (cur_note != 32'd0) && (cur_cd != 32'd0) && (cd_dec == 32'd0);
                    end
                    default: begin
                        hit = 1'b0;
                    end
                endcase

                // Stall the step while an earlier result cannot move on
                can_go = !hit || !r_hold_valid || out_free;

                if (can_go) begin
                    if (hit) begin
                        push         = r_hold_valid;
                        push_res     = r_hold;
                        push_last    = 1'b0;
                        n_hold_valid = 1'b1;
                        n_hold       = '{action: ACT_RELEASE, voice: 3'(r_idx), note: cur_note};
                    end

                    unique case (r_cmd.func)
                        FN_NOTE_ON: begin
                            // Track first same-note voice, first free voice, best victim
                            if (!r_match_found && (cur_note == r_cmd.note) && cur_act) begin
                                n_match_found = 1'b1;
                                n_match_idx   = r_idx;
                            end
                            if (!r_free_found && ((cur_note == 32'd0) || !cur_act)) begin
                                n_free_found = 1'b1;
                                n_free_idx   = r_idx;
                            end
                            if ((cur_note != 32'd0) && cur_act) begin
                                if (!r_steal_have) begin
                                    take = 1'b1;
                                end else if (cur_rel != r_best_rel) begin
                                    take = cur_rel;
                                end else if (cur_lvl != r_best_lvl) begin
                                    take = (cur_lvl < r_best_lvl);
                                end else begin
                                    take = (cur_ord < r_best_ord);
                                end
                            end
                            if (take) begin
                                n_steal_have = 1'b1;
                                n_steal_idx  = r_idx;
                                n_best_rel   = cur_rel;
                                n_best_lvl   = cur_lvl;
                                n_best_ord   = cur_ord;
                            end
                        end
                        FN_NOTE_OFF: begin
                            if (hit) begin
                                wr_cd_en  = 1'b1;
                                wr_cd     = 32'd0;
                                wr_rel_en = 1'b1;
                                wr_rel    = 1'b1;
                            end
                        end
                        FN_TICK: begin
                            // Count down, release on zero, free a silent voice
                            if (cur_note != 32'd0) begin
                                if (!cur_act) begin
                                    wr_key_en = 1'b1;
                                    wr_cd_en  = 1'b1;
                                    wr_rel_en = 1'b1;
                                end else begin
                                    if (cur_cd != 32'd0) begin
                                        wr_cd_en = 1'b1;
                                        wr_cd    = cd_dec;
                                    end
                                    if (hit) begin
                                        wr_rel_en = 1'b1;
                                        wr_rel    = 1'b1;
                                    end
                                end
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase

                    if (r_cmd.func == FN_NOTE_ON) begin
                        if (cur_last) begin
                            n_state = ST_COMMIT;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end else if (r_cmd.func != FN_STATUS) begin
                        if (stop) begin
                            n_state = ST_FLUSH;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                end
            end

            ST_COMMIT: begin
                // Place the note on the chosen voice and report the start
                if (r_match_found) begin
                    pick = r_match_idx;
                end else if (r_free_found) begin
                    pick = r_free_idx;
                end else if (r_steal_have) begin
                    pick = r_steal_idx;
                end else begin
                    pick = '0;
                end
                wr_idx = pick;
                if (out_free) begin
                    wr_key_en   = 1'b1;
                    wr_note     = r_cmd.note;
                    wr_ord      = r_start_cnt;
                    wr_cd_en    = 1'b1;
                    wr_cd       = r_cmd.dur;
                    wr_rel_en   = 1'b1;
                    wr_rel      = 1'b0;
                    wr_act_en   = 1'b1;
                    wr_act      = 1'b1;
                    wr_lvl      = 16'd0;
                    n_start_cnt = r_start_cnt + 64'd1;
                    push        = 1'b1;
                    push_res    = '{action: ACT_START, voice: 3'(pick), note: r_cmd.note};
                    push_last   = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            ST_FLUSH: begin
                // Send the held result as the final one
                if (!r_hold_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    push         = 1'b1;
                    push_res     = r_hold;
                    push_last    = 1'b1;
                    n_hold_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer and tracker registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_hold_valid <= 1'b0;
            r_start_cnt  <= 64'd1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_hold_valid <= n_hold_valid;
            r_start_cnt  <= n_start_cnt;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_idx         <= n_idx;
        r_match_found <= n_match_found;
        r_match_idx   <= n_match_idx;
        r_free_found  <= n_free_found;
        r_free_idx    <= n_free_idx;
        r_steal_have  <= n_steal_have;
        r_steal_idx   <= n_steal_idx;
        r_best_rel    <= n_best_rel;
        r_best_lvl    <= n_best_lvl;
        r_best_ord    <= n_best_ord;
        r_hold        <= n_hold;
        if (push) begin
            r_out      <= push_res;
            r_out_last <= push_last;
        end
    end

    // Slot storage: clear on reset, write one voice per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
                r_note[v] <= 32'd0;
                r_cd[v]   <= 32'd0;
                r_ord[v]  <= 64'd0;
                r_rel[v]  <= 1'b0;
                r_act[v]  <= 1'b0;
                r_lvl[v]  <= 16'd0;
            end
        end else begin
            if (wr_key_en) begin
                r_note[wr_idx] <= wr_note;
                r_ord[wr_idx]  <= wr_ord;
            end
            if (wr_cd_en) begin
                r_cd[wr_idx] <= wr_cd;
            end
            if (wr_rel_en) begin
                r_rel[wr_idx] <= wr_rel;
            end
            if (wr_act_en) begin
                r_act[wr_idx] <= wr_act;
                r_lvl[wr_idx] <= wr_lvl;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_action      = r_out.action;
    assign o_voice_index = r_out.voice;
    assign o_note_id_out = r_out.note;
    assign o_last        = r_out_last;

    a_hold_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |-> (r_state == ST_SCAN || r_state == ST_FLUSH))
        else $error("held result outside a scan");
    a_commit_note_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT) |-> (r_cmd.func == FN_NOTE_ON && r_cmd.note != 32'd0))
        else $error("commit without a valid note on");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_free)
        else $error("result pushed onto a stalled output");
    a_flush_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && r_hold_valid && out_free) |=> (r_state == ST_IDLE && !r_hold_valid))
        else $error("final result not sent");

endmodule

FILE: bench/tb_synth_voice_allocator_unit.sv
// Self-checking bench for synth_voice_allocator_unit: directed table, then random items.
// Checks each result against a typed expectation or a voice-slot predictor kept in the bench.
// Depends on vac_pkg and the synth_voice_allocator_unit RTL.
`timescale 1ns / 1ps

module tb_synth_voice_allocator_unit;

    import vac_pkg::*;

    localparam int NUM_VOICES   = DEF_NUM_VOICES;
    localparam int BY_MODEL     = -1;
    localparam int RANDOM_ITEMS = 200;
    localparam int CALM_TAIL    = 30;
    localparam int DRAIN_CYCLES = 40;

    // One input item, with an optional typed expectation (0 or 1 result)
    typedef struct {
        t_func       func;
        logic [31:0] note;
        logic [31:0] dur;
        logic [2:0]  sel;
        logic        act;
        logic [15:0] level;
        int          typed_n;
        t_action     typed_action;
        logic [2:0]  typed_voice;
        logic [31:0] typed_note;
    } t_stim_item;

    typedef struct {
        t_result res;
        logic    last;
    } t_voice_action;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_func = 2'd0;
    logic [31:0] i_note_id = 32'd0;
    logic [31:0] i_duration_frames = 32'd0;
    logic [2:0]  i_voice_select = 3'd0;
    logic        i_voice_active = 1'b0;
    logic [15:0] i_envelope_level = 16'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_action;
    logic [2:0]  o_voice_index;
    logic [31:0] o_note_id_out;
    logic        o_last;

    // Predictor copy of the voice slots
    logic [31:0] slot_note      [NUM_VOICES];
    logic [31:0] slot_countdown [NUM_VOICES];
    logic [63:0] slot_order     [NUM_VOICES];
    logic        slot_releasing [NUM_VOICES];
    logic        slot_active    [NUM_VOICES];
    logic [15:0] slot_level     [NUM_VOICES];
    logic [63:0] start_counter;

    t_stim_item    stim_items[$];
    t_voice_action fresh_actions[$];
    t_voice_action expected_actions[$];

    int   item_idx = 0;
    int   fail_count = 0;
    int   in_gap = 0;
    int   out_gap = 0;
    int   cycle_count = 0;
    logic idle_enable = 1'b1;

    synth_voice_allocator_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_note_id         (i_note_id),
        .i_duration_frames (i_duration_frames),
        .i_voice_select    (i_voice_select),
        .i_voice_active    (i_voice_active),
        .i_envelope_level  (i_envelope_level),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_action          (o_action),
        .o_voice_index     (o_voice_index),
        .o_note_id_out     (o_note_id_out),
        .o_last            (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Append one item to the stimulus list
    function automatic void add_stim(t_stim_item s);
        stim_items.insert(stim_items.size(), s);
    endfunction

    // Append one result to the expected list
    function automatic void add_expect(t_voice_action a);
        expected_actions.insert(expected_actions.size(), a);
    endfunction

    // Record one result of the predictor
    function automatic void note_action(t_action act, int v, logic [31:0] note);
        t_voice_action a;
        a.res.action = act;
        a.res.voice  = 3'(v);
        a.res.note   = note;
        a.last       = 1'b0;
        fresh_actions.insert(fresh_actions.size(), a);
    endfunction

    // Release a voice if it holds a note and still sounds
    function automatic logic release_voice(int v);
        if (slot_note[v] == 32'd0 || !slot_active[v])
            return 1'b0;
        slot_countdown[v] = 32'd0;
        slot_releasing[v] = 1'b1;
        return 1'b1;
    endfunction

    // Advance the voice slots by one item, leave its results in fresh_actions
    function automatic void step_voice_slots(t_stim_item it);
        int  v;
        int  pick;
        logic found;
        fresh_actions.delete();
        case (it.func)
            FN_NOTE_ON: begin
                if (it.note != 32'd0) begin
                    found = 1'b0;
                    pick = 0;
                    // Retrigger a voice already sounding this note
                    for (v = 0; v < NUM_VOICES; v++)
                        if (!found && slot_note[v] == it.note && slot_active[v]) begin
                            pick = v;
                            found = 1'b1;
                        end
                    // Else take the lowest free voice
                    for (v = 0; v < NUM_VOICES; v++)
                        if (!found && (slot_note[v] == 32'd0 || !slot_active[v])) begin
                            pick = v;
                            found = 1'b1;
                        end
                    // Else steal: releasing, then lowest level, then oldest start
                    if (!found) begin
                        for (v = 0; v < NUM_VOICES; v++) begin
                            if (slot_note[v] != 32'd0 && slot_active[v]) begin
                                if (!found) begin
                                    pick = v;
                                    found = 1'b1;
                                end else if (slot_releasing[v] != slot_releasing[pick]) begin
                                    if (slot_releasing[v])
                                        pick = v;
                                end else if (slot_level[v] != slot_level[pick]) begin
                                    if (slot_level[v] < slot_level[pick])
                                        pick = v;
                                end else if (slot_order[v] < slot_order[pick]) begin
                                    pick = v;
                                end
                            end
                        end
                    end
                    slot_note[pick]      = it.note;
                    slot_order[pick]     = start_counter;
                    start_counter        = start_counter + 64'd1;
                    slot_releasing[pick] = 1'b0;
                    slot_countdown[pick] = it.dur;
                    slot_active[pick]    = 1'b1;
                    slot_level[pick]     = 16'd0;
                    note_action(ACT_START, pick, it.note);
                end
            end
            FN_NOTE_OFF: begin
                if (it.note == 32'd0) begin
                    for (v = 0; v < NUM_VOICES; v++)
                        if (release_voice(v))
                            note_action(ACT_RELEASE, v, slot_note[v]);
                end else begin
                    found = 1'b0;
                    for (v = 0; v < NUM_VOICES; v++)
                        if (!found && slot_note[v] == it.note) begin
                            found = 1'b1;
                            if (release_voice(v))
                                note_action(ACT_RELEASE, v, slot_note[v]);
                        end
                end
            end
            FN_STATUS: begin
                if (int'(it.sel) < NUM_VOICES) begin
                    slot_active[it.sel] = it.act;
                    slot_level[it.sel]  = it.level;
                end
            end
            default: begin
                for (v = 0; v < NUM_VOICES; v++) begin
                    if (slot_note[v] != 32'd0) begin
                        if (slot_countdown[v] != 32'd0) begin
                            slot_countdown[v] = slot_countdown[v] - 32'd1;
                            if (slot_countdown[v] == 32'd0) begin
                                slot_releasing[v] = 1'b1;
                                note_action(ACT_RELEASE, v, slot_note[v]);
                            end
                        end
                        if (!slot_active[v]) begin
                            slot_note[v]      = 32'd0;
                            slot_countdown[v] = 32'd0;
                            slot_order[v]     = 64'd0;
                            slot_releasing[v] = 1'b0;
                        end
                    end
                end
            end
        endcase
        if (fresh_actions.size() > 0)
            fresh_actions[fresh_actions.size() - 1].last = 1'b1;
    endfunction

    // Draw a note id: mostly a small pool so that retrigger and note off hit
    function automatic logic [31:0] draw_note();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return 32'($urandom_range(1, 12));
        else if (r < 95)
            return 32'($urandom);
        return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
    endfunction

    // Build the directed table and the random items
    initial begin
        t_stim_item it;
        int counted;
        int r;
        int n;

        for (n = 0; n < NUM_VOICES; n++) begin
            slot_note[n]      = 32'd0;
            slot_countdown[n] = 32'd0;
            slot_order[n]     = 64'd0;
            slot_releasing[n] = 1'b0;
            slot_active[n]    = 1'b0;
            slot_level[n]     = 16'd0;
        end
        start_counter = 64'd1;

        // Empty slots: tick, release all and a zero note on give nothing
        add_stim('{FN_TICK, 0, 0, 0, 0, 0, 0, ACT_START, 0, 0});
        add_stim('{FN_NOTE_OFF, 0, 0, 0, 0, 0, 0, ACT_START, 0, 0});
        add_stim('{FN_NOTE_ON, 0, 5, 0, 0, 0, 0, ACT_START, 0, 0});
        // Extreme note id and duration, then a timed note, then a retrigger
        add_stim('{FN_NOTE_ON, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0,
                   1, ACT_START, 0, 32'hFFFF_FFFF});
        add_stim('{FN_NOTE_ON, 1, 2, 0, 0, 0, 1, ACT_START, 1, 1});
        add_stim('{FN_NOTE_ON, 32'hFFFF_FFFF, 0, 0, 0, 0,
                   1, ACT_START, 0, 32'hFFFF_FFFF});
        // Note off with no matching voice
        add_stim('{FN_NOTE_OFF, 5, 0, 0, 0, 0, 0, ACT_START, 0, 0});
        // Auto release after two ticks, then free the silent voice
        add_stim('{FN_TICK, 0, 0, 0, 0, 0, 0, ACT_START, 0, 0});
        add_stim('{FN_TICK, 0, 0, 0, 0, 0, 1, ACT_RELEASE, 1, 1});
        add_stim('{FN_STATUS, 0, 0, 1, 0, 0, 0, ACT_START, 0, 0});
        add_stim('{FN_TICK, 0, 0, 0, 0, 0, 0, ACT_START, 0, 0});
        // Fill the remaining voices
        for (n = 2; n <= NUM_VOICES; n++)
            add_stim('{FN_NOTE_ON, 32'(n), 0, 0, 0, 0,
                       1, ACT_START, 3'(n - 1), 32'(n)});
        // Levels, then a release and two steals
        add_stim('{FN_STATUS, 0, 0, 3, 1, 16'h8000, 0, ACT_START, 0, 0});
        add_stim('{FN_STATUS, 0, 0, 5, 1, 16'hFFFF, 0, ACT_START, 0, 0});
        add_stim('{FN_NOTE_OFF, 4, 0, 0, 0, 0, 1, ACT_RELEASE, 3, 4});
        add_stim('{FN_NOTE_ON, 9, 3, 0, 0, 0, BY_MODEL, ACT_START, 0, 0});
        add_stim('{FN_NOTE_ON, 10, 0, 0, 0, 0, BY_MODEL, ACT_START, 0, 0});
        add_stim('{FN_NOTE_OFF, 0, 0, 0, 0, 0, BY_MODEL, ACT_START, 0, 0});
        add_stim('{FN_TICK, 0, 0, 0, 0, 0, BY_MODEL, ACT_START, 0, 0});

        // Random items; unused fields carry random values
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            it.note    = 32'($urandom);
            it.dur     = 32'($urandom);
            it.sel     = 3'($urandom_range(0, 7));
            it.act     = 1'($urandom_range(0, 1));
            it.level   = 16'($urandom_range(0, 65535));
            it.typed_n = BY_MODEL;
            it.typed_action = ACT_START;
            it.typed_voice  = 3'd0;
            it.typed_note   = 32'd0;
            r = $urandom_range(0, 99);
            if (r < 32) begin
                it.func = FN_NOTE_ON;
                it.note = ($urandom_range(0, 49) == 0) ? 32'd0 : draw_note();
                r = $urandom_range(0, 99);
                if (r < 50)
                    it.dur = 32'd0;
                else if (r < 85)
                    it.dur = 32'($urandom_range(1, 6));
            end else if (r < 52) begin
                it.func = FN_NOTE_OFF;
                it.note = ($urandom_range(0, 11) == 0) ? 32'd0 : draw_note();
            end else if (r < 76) begin
                it.func = FN_STATUS;
                it.act  = ($urandom_range(0, 9) < 6);
                if ($urandom_range(0, 1) == 0)
                    it.level = 16'($urandom_range(0, 3) * 16'h5555);
            end else begin
                it.func = FN_TICK;
            end
            add_stim(it);
            // Skip zero-id note on items in the count, the block ignores them
            if (!(it.func == FN_NOTE_ON && it.note == 32'd0))
                counted++;
        end

        // Hold reset, then release it
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for all items, all results, then a quiet drain
        wait (item_idx == stim_items.size());
        while (expected_actions.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("synth_voice_allocator_unit verification clean");
        else
            $display("synth_voice_allocator_unit verification failed");
        $finish;
    end

    // Abort a hung run
    initial begin
        #2_000_000;
        $display("synth_voice_allocator_unit verification failed");
        $finish;
    end

    // Toggle idling in stretches, drop it for the tail of the run
    always @(posedge i_clk) begin
        cycle_count++;
        if (item_idx + CALM_TAIL >= stim_items.size())
            idle_enable <= 1'b0;
        else if (cycle_count % 40 == 0)
            idle_enable <= ($urandom_range(0, 9) < 7);
    end

    // Drive input items; predict each one as it is taken
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                step_voice_slots(stim_items[item_idx]);
                if (stim_items[item_idx].typed_n == BY_MODEL) begin
                    foreach (fresh_actions[k])
                        add_expect(fresh_actions[k]);
                end else if (stim_items[item_idx].typed_n > 0) begin
                    add_expect('{'{stim_items[item_idx].typed_action,
                                   stim_items[item_idx].typed_voice,
                                   stim_items[item_idx].typed_note},
                                 1'b1});
                end
                item_idx++;
            end
            // Hold a stalled item, else choose the next item or a gap
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (item_idx < stim_items.size()) begin
                    if (idle_enable && $urandom_range(0, 5) == 0) begin
                        in_gap = $urandom_range(0, 9);
                        i_in_valid <= 1'b0;
                    end else begin
                        i_in_valid        <= 1'b1;
                        i_func            <= stim_items[item_idx].func;
                        i_note_id         <= stim_items[item_idx].note;
                        i_duration_frames <= stim_items[item_idx].dur;
                        i_voice_select    <= stim_items[item_idx].sel;
                        i_voice_active    <= stim_items[item_idx].act;
                        i_envelope_level  <= stim_items[item_idx].level;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Check each result against the oldest expectation; stall in bursts
    always @(posedge i_clk) begin
        t_voice_action exp_a;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_actions.size() == 0) begin
                    $error("unexpected result: action %0d voice %0d note %0h last %0d",
                           o_action, o_voice_index, o_note_id_out, o_last);
                    fail_count++;
                end else begin
                    exp_a = expected_actions.pop_front();
                    if (o_action !== exp_a.res.action) begin
                        $error("action: expected %0d, got %0d", exp_a.res.action, o_action);
                        fail_count++;
                    end
                    if (o_voice_index !== exp_a.res.voice) begin
                        $error("voice_index: expected %0d, got %0d",
                               exp_a.res.voice, o_voice_index);
                        fail_count++;
                    end
                    if (o_note_id_out !== exp_a.res.note) begin
                        $error("note_id_out: expected %0h, got %0h",
                               exp_a.res.note, o_note_id_out);
                        fail_count++;
                    end
                    if (o_last !== exp_a.last) begin
                        $error("last: expected %0d, got %0d", exp_a.last, o_last);
                        fail_count++;
                    end
                end
            end
            if (out_gap > 0)
                out_gap--;
            else if (idle_enable && $urandom_range(0, 4) == 0)
                out_gap = $urandom_range(1, 10);
            i_out_stall <= (out_gap > 0);
        end
    end

endmodule
